FILE: src/vcu_pkg.sv
// vcu_pkg: shared types, constants and helpers of the vector clock unit
`default_nettype none

package vcu_pkg;

	localparam int MAX_NODES = 16;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int VAL_W     = 32;

	localparam logic [1:0] MODE_INTERNAL = 2'd0;
	localparam logic [1:0] MODE_SEND     = 2'd1;
	localparam logic [1:0] MODE_RECEIVE  = 2'd2;

	localparam logic REG_OWN_INDEX  = 1'b0;
	localparam logic REG_NODE_COUNT = 1'b1;

	localparam logic [VAL_W-1:0] SAT_MAX = '1;

	typedef struct packed {
		logic [1:0]       mode;
		logic [IDX_W-1:0] element_index;
		logic [VAL_W-1:0] element_value;
		logic             element_last;
	} vcu_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] entry_index;
		logic [VAL_W-1:0] entry_value;
		logic             entry_last;
		logic [VAL_W-1:0] internal_events;
		logic [VAL_W-1:0] send_events;
		logic [VAL_W-1:0] receive_events;
	} vcu_result_t;

	typedef struct packed {
		logic load;
		logic clr_k;
		logic rd_own;
		logic wr_own;
		logic rd_el;
		logic wr_el;
		logic bump;
		logic rd_out;
	} vcu_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       idx_zero;
		logic       last;
		logic       k_last;
		logic       pipe_busy;
	} vcu_status_t;

	function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] r;
		r = (v == SAT_MAX) ? v : v + VAL_W'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/vcu_ctrl.sv
// vcu_ctrl: sequencing state machine of the vector clock unit
`default_nettype none

module vcu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire vcu_pkg::vcu_status_t status,
	output vcu_pkg::vcu_cmd_t         cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DISPATCH = 7'b0000010,
		ST_OWN_RD   = 7'b0000100,
		ST_OWN_WR   = 7'b0001000,
		ST_EL_RD    = 7'b0010000,
		ST_EL_WR    = 7'b0100000,
		ST_READ     = 7'b1000000
	} vcu_state_t;

	vcu_state_t state_q;
	vcu_state_t state_d;
	logic       draining_q;
	logic       need_own;
	logic       is_event;

	assign is_event = (status.mode == vcu_pkg::MODE_INTERNAL) ||
		(status.mode == vcu_pkg::MODE_SEND);
	assign need_own = is_event ||
		((status.mode == vcu_pkg::MODE_RECEIVE) && status.idx_zero);

	assign busy = (state_q != ST_IDLE) || draining_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && !draining_q) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.clr_k = 1'b1;
				if (need_own) begin
					state_d = ST_OWN_RD;
				end else if (status.mode == vcu_pkg::MODE_RECEIVE) begin
					state_d = ST_EL_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OWN_RD: begin
				cmd.rd_own = 1'b1;
				state_d    = ST_OWN_WR;
			end
			ST_OWN_WR: begin
				cmd.wr_own = 1'b1;
				if (is_event) begin
					cmd.bump = 1'b1;
					state_d  = ST_READ;
				end else begin
					state_d = ST_EL_RD;
				end
			end
			ST_EL_RD: begin
				cmd.rd_el = 1'b1;
				state_d   = ST_EL_WR;
			end
			ST_EL_WR: begin
				cmd.wr_el = 1'b1;
				if (status.last) begin
					cmd.bump = 1'b1;
					state_d  = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_out = 1'b1;
				if (status.k_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			draining_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			draining_q <= (state_q == ST_READ && status.k_last) ||
				(draining_q && status.pipe_busy);
		end
	end

endmodule

`default_nettype wire

FILE: src/vcu_datapath.sv
// vcu_datapath: clock entry memory, event counters, configuration and readout
`default_nettype none

module vcu_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire vcu_pkg::vcu_cmd_t    cmd,
	output vcu_pkg::vcu_status_t      status,
	input  wire vcu_pkg::vcu_item_t   item,
	input  wire logic                 write_enable,
	input  wire logic                 write_index,
	input  wire logic [4:0]           write_data,
	output logic                      strobe,
	output vcu_pkg::vcu_result_t      result
);

	vcu_pkg::vcu_item_t          item_q;
	logic [vcu_pkg::IDX_W-1:0]   own_q;
	logic [vcu_pkg::CNT_W-1:0]   node_q;
	logic [vcu_pkg::VAL_W-1:0]   internal_q;
	logic [vcu_pkg::VAL_W-1:0]   send_q;
	logic [vcu_pkg::VAL_W-1:0]   receive_q;
	logic [vcu_pkg::IDX_W-1:0]   k_q;

	logic [vcu_pkg::VAL_W-1:0]   mem [vcu_pkg::MAX_NODES];
	logic [vcu_pkg::MAX_NODES-1:0] vld_q;
	logic [vcu_pkg::VAL_W-1:0]   mem_rd_q;
	logic                        vld_rd_q;

	logic                        rd_s1;
	logic [vcu_pkg::IDX_W-1:0]   k_s1;
	logic                        last_s1;
	logic                        strobe_q;
	vcu_pkg::vcu_result_t        result_q;

	logic [vcu_pkg::CNT_W-1:0]   active;
	logic [vcu_pkg::IDX_W-1:0]   addr;
	logic [vcu_pkg::VAL_W-1:0]   entry_val;
	logic                        own_ok;
	logic                        el_ok;
	logic                        wr_en;
	logic [vcu_pkg::VAL_W-1:0]   wr_val;
	logic                        k_last;

	// effective node count
	always_comb begin
		if (node_q == '0) begin
			active = vcu_pkg::CNT_W'(1);
		end else if (node_q > vcu_pkg::CNT_W'(vcu_pkg::MAX_NODES)) begin
			active = vcu_pkg::CNT_W'(vcu_pkg::MAX_NODES);
		end else begin
			active = node_q;
		end
	end

	always_comb begin
		if (cmd.rd_own || cmd.wr_own) begin
			addr = own_q;
		end else if (cmd.rd_el || cmd.wr_el) begin
			addr = item_q.element_index;
		end else begin
			addr = k_q;
		end
	end

	assign entry_val = vld_rd_q ? mem_rd_q : '0;
	assign own_ok    = {1'b0, own_q} < vcu_pkg::CNT_W'(vcu_pkg::MAX_NODES);
	assign el_ok     = ({1'b0, item_q.element_index} < active) &&
		(entry_val < item_q.element_value);
	assign wr_en     = (cmd.wr_own && own_ok) || (cmd.wr_el && el_ok);
	assign wr_val    = cmd.wr_own ? vcu_pkg::sat_inc(entry_val) : item_q.element_value;
	assign k_last    = ({1'b0, k_q} + vcu_pkg::CNT_W'(1)) == active;

	assign status.mode      = item_q.mode;
	assign status.idx_zero  = item_q.element_index == '0;
	assign status.last      = item_q.element_last;
	assign status.k_last    = k_last;
	assign status.pipe_busy = rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_val;
		end
		if (cmd.rd_own || cmd.rd_el || cmd.rd_out) begin
			mem_rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (cmd.rd_own || cmd.rd_el || cmd.rd_out) begin
				vld_rd_q <= vld_q[addr];
			end
		end
	end

	// payload of the latched transaction, readout pipeline and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		k_s1    <= k_q;
		last_s1 <= k_last;
		if (rd_s1) begin
			result_q.entry_index     <= k_s1;
			result_q.entry_value     <= entry_val;
			result_q.entry_last      <= last_s1;
			result_q.internal_events <= internal_q;
			result_q.send_events     <= send_q;
			result_q.receive_events  <= receive_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q      <= '0;
			node_q     <= vcu_pkg::CNT_W'(vcu_pkg::MAX_NODES);
			internal_q <= '0;
			send_q     <= '0;
			receive_q  <= '0;
			k_q        <= '0;
			rd_s1      <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (write_enable) begin
				case (write_index)
					vcu_pkg::REG_OWN_INDEX:  own_q  <= write_data[vcu_pkg::IDX_W-1:0];
					vcu_pkg::REG_NODE_COUNT: node_q <= write_data;
					default: ;
				endcase
			end
			if (cmd.bump) begin
				case (item_q.mode)
					vcu_pkg::MODE_INTERNAL: internal_q <= vcu_pkg::sat_inc(internal_q);
					vcu_pkg::MODE_SEND:     send_q     <= vcu_pkg::sat_inc(send_q);
					vcu_pkg::MODE_RECEIVE:  receive_q  <= vcu_pkg::sat_inc(receive_q);
					default: ;
				endcase
			end
			if (cmd.clr_k) begin
				k_q <= '0;
			end else if (cmd.rd_out) begin
				k_q <= k_q + vcu_pkg::IDX_W'(1);
			end
			rd_s1    <= cmd.rd_out;
			strobe_q <= rd_s1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_no_write_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_out && (cmd.wr_own || cmd.wr_el)))
		else $error("clock entry written during readout");

	a_strobe_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(rd_s1))
		else $error("result strobe without a readout access");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && result_q.entry_last) |->
		(({1'b0, result_q.entry_index} + vcu_pkg::CNT_W'(1)) == active))
		else $error("last flag on wrong entry");

	a_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.bump) |-> ($stable(internal_q) && $stable(send_q) && $stable(receive_q)))
		else $error("event counter moved without an event");

endmodule

`default_nettype wire

FILE: src/vector_clock_unit.sv
// vector_clock_unit: top level of the vector clock unit
// A transaction is taken when start is high and busy is low, one at a time.
// Internal and send events keep busy high from acceptance through
// dispatch, a read and write-back of the own entry in the single-port entry
// memory and one memory read per reported entry, until the last result has
// left the output pipeline. A received element takes dispatch and a read and
// write of its entry; at position 0 it first advances the own entry, and
// the last element then adds the readout as well. Results come out one per
// cycle, each registered in the entry memory read register and then in the
// result register after its readout access, each on result for exactly one
// cycle with strobe high; the receiver cannot stall them. Configuration
// writes take effect at once and are meant for idle periods only.
`default_nettype none

module vector_clock_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire vcu_pkg::vcu_item_t   item,
	output logic                      strobe,
	output vcu_pkg::vcu_result_t      result,
	input  wire logic                 write_enable,
	input  wire logic                 write_index,
	input  wire logic [4:0]           write_data
);

	vcu_pkg::vcu_cmd_t    cmd;
	vcu_pkg::vcu_status_t status;

	vcu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	vcu_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.strobe       (strobe),
		.result       (result)
	);

endmodule

`default_nettype wire
